// ----- hdl/urtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_pkg
// Types and constants shared by the UART receive/transmit ring buffer core.
// ----------------------------------------------------------------------------
package urtb_pkg;

    // Operation codes carried in the opcode field of an input item
    localparam logic [2:0] OP_HOST_READ  = 3'd0;
    localparam logic [2:0] OP_HOST_WRITE = 3'd1;
    localparam logic [2:0] OP_LINE_RX    = 3'd2;
    localparam logic [2:0] OP_TX_DONE    = 3'd3;
    localparam logic [2:0] OP_CLEAR_RX   = 3'd4;
    localparam logic [2:0] OP_READ_OVF   = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = 7;
    localparam logic [0:0]  CFG_RX_SIZE = 1'd0;
    localparam logic [0:0]  CFG_TX_SIZE = 1'd1;

    // Smallest usable ring length
    localparam int          MIN_LEN     = 2;

    // Input item
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data;
        logic [2:0] line_errors;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic       done_res;
        logic [7:0] read_byte;
        logic       send_now;
        logic [7:0] send_byte;
        logic       overflow_seen;
        logic [2:0] last_line_errors;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // latch the accepted item
        logic exec;   // apply the item to the rings and flags
        logic emit;   // result is on the output this cycle
    } t_ctrl_cmd;

endpackage

// ----- hdl/urtb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/urtb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ctrl
// Item sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
module urtb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output urtb_pkg::t_ctrl_cmd o_cmd
);
    import urtb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // New item taken whenever execute is not in progress
    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.emit = (r_state == S_RESP);

endmodule

// ----- hdl/urtb_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_dpath
// Ring indices, flags, size registers and the two byte stores.
// ----------------------------------------------------------------------------
module urtb_dpath #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  urtb_pkg::t_ctrl_cmd                 i_cmd,
    input  urtb_pkg::t_in_item                  i_item,
    input  logic                                i_cfg_we,
    input  logic [urtb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [urtb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output urtb_pkg::t_out_item                 o_result
);
    import urtb_pkg::*;

    localparam int RIW = $clog2(RX_DEPTH);
    localparam int RLW = $clog2(RX_DEPTH + 1);
    localparam int TIW = $clog2(TX_DEPTH);
    localparam int TLW = $clog2(TX_DEPTH + 1);
    localparam int RX_RST_LEN = (RX_DEPTH < 64) ? RX_DEPTH : 64;
    localparam int TX_RST_LEN = (TX_DEPTH < 64) ? TX_DEPTH : 64;

    // Latched item
    t_in_item       r_item;

    // Ring state
    logic [RLW-1:0] r_rx_len;
    logic [TLW-1:0] r_tx_len;
    logic [RIW-1:0] r_rx_rd, n_rx_rd, r_rx_wr, n_rx_wr;
    logic [TIW-1:0] r_tx_rd, n_tx_rd, r_tx_wr, n_tx_wr;
    logic           r_tx_busy, n_tx_busy;
    logic           r_ovf, n_ovf;
    logic [2:0]     r_err, n_err;

    // Result registers
    logic           r_done, n_done;
    logic           r_rd_ok, n_rd_ok;
    logic           r_snow, n_snow;
    logic           r_snow_ram, n_snow_ram;
    logic           r_ovf_seen;

    // Ring helpers
    logic [RLW-1:0] rx_rd_inc, rx_wr_inc;
    logic [TLW-1:0] tx_rd_inc, tx_wr_inc;
    logic [RIW-1:0] rx_rd_adv, rx_wr_adv;
    logic [TIW-1:0] tx_rd_adv, tx_wr_adv;
    logic           rx_empty, rx_full, tx_empty, tx_full;
    logic           rx_we, tx_we;
    logic [7:0]     rx_rdata, tx_rdata;
    logic [RLW-1:0] rx_cfg_len;
    logic [TLW-1:0] tx_cfg_len;

    // Index advance with wrap at the ring length in use
    assign rx_rd_inc = RLW'(r_rx_rd) + RLW'(1);
    assign rx_wr_inc = RLW'(r_rx_wr) + RLW'(1);
    assign tx_rd_inc = TLW'(r_tx_rd) + TLW'(1);
    assign tx_wr_inc = TLW'(r_tx_wr) + TLW'(1);
    assign rx_rd_adv = (rx_rd_inc >= r_rx_len) ? '0 : rx_rd_inc[RIW-1:0];
    assign rx_wr_adv = (rx_wr_inc >= r_rx_len) ? '0 : rx_wr_inc[RIW-1:0];
    assign tx_rd_adv = (tx_rd_inc >= r_tx_len) ? '0 : tx_rd_inc[TIW-1:0];
    assign tx_wr_adv = (tx_wr_inc >= r_tx_len) ? '0 : tx_wr_inc[TIW-1:0];

    assign rx_empty = (r_rx_rd == r_rx_wr);
    assign rx_full  = (rx_wr_adv == r_rx_rd);
    assign tx_empty = (r_tx_rd == r_tx_wr);
    assign tx_full  = (tx_wr_adv == r_tx_rd);

    // Size write, saturated to the usable range
    always_comb begin
        if (int'(i_cfg_wdata) < MIN_LEN) begin
            rx_cfg_len = RLW'(MIN_LEN);
        end else if (int'(i_cfg_wdata) > RX_DEPTH) begin
            rx_cfg_len = RLW'(RX_DEPTH);
        end else begin
            rx_cfg_len = RLW'(i_cfg_wdata);
        end
        if (int'(i_cfg_wdata) < MIN_LEN) begin
            tx_cfg_len = TLW'(MIN_LEN);
        end else if (int'(i_cfg_wdata) > TX_DEPTH) begin
            tx_cfg_len = TLW'(TX_DEPTH);
        end else begin
            tx_cfg_len = TLW'(i_cfg_wdata);
        end
    end

    // Operation decode
    always_comb begin
        n_rx_rd    = r_rx_rd;
        n_rx_wr    = r_rx_wr;
        n_tx_rd    = r_tx_rd;
        n_tx_wr    = r_tx_wr;
        n_tx_busy  = r_tx_busy;
        n_ovf      = r_ovf;
        n_err      = r_err;
        n_done     = 1'b0;
        n_rd_ok    = 1'b0;
        n_snow     = 1'b0;
        n_snow_ram = 1'b0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        unique case (r_item.opcode)
            OP_HOST_READ: begin
                if (!rx_empty) begin
                    n_done  = 1'b1;
                    n_rd_ok = 1'b1;
                    n_rx_rd = rx_rd_adv;
                end
            end
            OP_HOST_WRITE: begin
                if (!r_tx_busy) begin
                    // transmitter idle: hand the byte over directly
                    n_tx_busy = 1'b1;
                    n_snow    = 1'b1;
                    n_done    = 1'b1;
                end else if (!tx_full) begin
                    tx_we   = 1'b1;
                    n_tx_wr = tx_wr_adv;
                    n_done  = 1'b1;
                end
            end
            OP_LINE_RX: begin
                n_err = r_item.line_errors;
                if (rx_full) begin
                    n_ovf = 1'b1;
                end else begin
                    rx_we   = 1'b1;
                    n_rx_wr = rx_wr_adv;
                end
            end
            OP_TX_DONE: begin
                if (r_tx_busy) begin
                    if (!tx_empty) begin
                        n_snow     = 1'b1;
                        n_snow_ram = 1'b1;
                        n_tx_rd    = tx_rd_adv;
                    end else begin
                        n_tx_busy = 1'b0;
                    end
                end
            end
            OP_CLEAR_RX: n_rx_wr = r_rx_rd;
            OP_READ_OVF: n_ovf = 1'b0;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_len  <= RLW'(RX_RST_LEN);
            r_tx_len  <= TLW'(TX_RST_LEN);
            r_rx_rd   <= '0;
            r_rx_wr   <= '0;
            r_tx_rd   <= '0;
            r_tx_wr   <= '0;
            r_tx_busy <= 1'b0;
            r_ovf     <= 1'b0;
            r_err     <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_RX_SIZE)) begin
                r_rx_len <= rx_cfg_len;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_TX_SIZE)) begin
                r_tx_len <= tx_cfg_len;
            end
            if (i_cmd.exec) begin
                r_rx_rd   <= n_rx_rd;
                r_rx_wr   <= n_rx_wr;
                r_tx_rd   <= n_tx_rd;
                r_tx_wr   <= n_tx_wr;
                r_tx_busy <= n_tx_busy;
                r_ovf     <= n_ovf;
                r_err     <= n_err;
            end
        end
    end

    // Item latch and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_done     <= n_done;
            r_rd_ok    <= n_rd_ok;
            r_snow     <= n_snow;
            r_snow_ram <= n_snow_ram;
            r_ovf_seen <= (r_item.opcode == OP_READ_OVF) ? r_ovf : n_ovf;
        end
    end

    // Byte stores; read data lands for the result cycle
    urtb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (r_item.data),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    urtb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (r_item.data),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // Result fields
    assign o_result.done_res         = r_done;
    assign o_result.read_byte        = r_rd_ok ? rx_rdata : 8'd0;
    assign o_result.send_now         = r_snow;
    assign o_result.send_byte        = !r_snow   ? 8'd0 :
                                       r_snow_ram ? tx_rdata : r_item.data;
    assign o_result.overflow_seen    = r_ovf_seen;
    assign o_result.last_line_errors = r_err;

endmodule

// ----- hdl/uart_rx_tx_ring_buffers_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_core
// UART byte buffering: receive ring and transmit ring with host/line ops.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (opcode, data, line_errors) is taken at a clock
//   edge where start is high and busy is low. Result channel: one result per
//   item, shown on o_result for one cycle with o_result_valid high; it must
//   be captured then, there is no hold-off.
//   Sequence: the accepting edge leads into the execute cycle, then the
//   result cycle, whose read data comes from the registered RAM read port.
//   Overlap: busy is high only in the execute cycle, so the next item is
//   taken while the previous result is shown.
//   Configuration: i_cfg_we writes ring length register i_cfg_idx (0 receive,
//   1 transmit), saturated to 2..depth. The user must write it only while no
//   item is in flight; the block itself does not enforce this.
//   Reset: indices, flags, error bits cleared, lengths set to 64 (or depth);
//   ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_core #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  urtb_pkg::t_in_item              i_item,
    output logic                            o_result_valid,
    output urtb_pkg::t_out_item             o_result,
    input  logic                            i_cfg_we,
    input  logic [urtb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urtb_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import urtb_pkg::*;

    t_ctrl_cmd cmd;

    // Sequencer
    urtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Rings and flags
    urtb_dpath #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

    assign o_result_valid = cmd.emit;

    // Every accepted item is followed by its execute cycle and then its result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_result_valid)
        else $error("result strobe missing after accepted item");

    // Execute and result cycles never overlap
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown during execute");

    // A byte is only returned by a successful host operation
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.done_res) |-> (o_result.read_byte == 8'd0))
        else $error("read byte nonzero without success");

    // Send byte is zero when nothing goes to the line
    a_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.send_now) |-> (o_result.send_byte == 8'd0))
        else $error("send byte nonzero without send");

endmodule

// ----- tb/uart_rx_tx_ring_buffers_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_core_tb
// Self-checking bench for the UART receive/transmit ring buffer core.
// A behavioral copy of both rings, the transmitter state and the sticky flags
// runs alongside the core. Each accepted item adds its result to a queue, and
// every strobed result is compared field by field with the oldest entry.
// Directed items cover the corner cases. Random traffic then runs under
// several ring lengths and sender idle rates.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_core_tb;
    import urtb_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int STALL_LIMIT = 2000;   // cycles with no item accepted and no result
    localparam int MAX_GAP     = 30;

    // Opcodes the core must treat as no-ops
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // Opcode picked by each weight slot of the random traffic mix
    localparam logic [2:0] OP_BY_SLOT [6] = '{OP_HOST_READ, OP_HOST_WRITE, OP_LINE_RX,
                                              OP_TX_DONE, OP_CLEAR_RX, OP_READ_OVF};

    // Traffic mixes: balanced, filling the rings, draining the rings
    localparam int MIX_EVEN  = 0;
    localparam int MIX_FILL  = 1;
    localparam int MIX_DRAIN = 2;
    localparam int MIX_CUT [3][6] = '{'{18, 36, 54, 72, 78, 92},
                                      '{ 8, 43, 78, 86, 88, 96},
                                      '{35, 43, 51, 86, 90, 96}};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in_item              i_item      = '0;
    logic                  o_result_valid;
    t_out_item             o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    uart_rx_tx_ring_buffers_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the core state
    logic [7:0]  rx_mem [RING_DEPTH];
    logic [7:0]  tx_mem [RING_DEPTH];
    logic [63:0] rx_written, tx_written;   // entries holding a known byte
    int          rx_rd, rx_wr, tx_rd, tx_wr;
    int          rx_len, tx_len;
    logic        tx_active, ovf_flag;
    logic [2:0]  err_bits;

    t_out_item   uart_replies [$];
    t_out_item   want;
    int          mismatches   = 0;
    int          stall_cycles = 0;
    int          idle_pct     = 0;

    function automatic int next_idx(int idx, int len);
        return (idx + 1 >= len) ? 0 : idx + 1;
    endfunction

    function automatic int ring_len(logic [CFG_DATA_W-1:0] v);
        if (v < MIN_LEN) return MIN_LEN;
        if (v > RING_DEPTH) return RING_DEPTH;
        return int'(v);
    endfunction

    // Apply one item to the shadow state and return the result it produces
    function automatic t_out_item uart_op_effect(t_in_item it);
        t_out_item r;
        logic      ovf_before;
        r          = '0;
        ovf_before = ovf_flag;
        case (it.opcode)
            OP_HOST_READ: begin
                if (rx_rd != rx_wr) begin
                    r.done_res  = 1'b1;
                    r.read_byte = rx_mem[rx_rd];
                    rx_rd       = next_idx(rx_rd, rx_len);
                end
            end
            OP_HOST_WRITE: begin
                if (!tx_active) begin
                    // transmitter idle: byte goes straight to the line
                    tx_active   = 1'b1;
                    r.send_now  = 1'b1;
                    r.send_byte = it.data;
                    r.done_res  = 1'b1;
                end else if (next_idx(tx_wr, tx_len) != tx_rd) begin
                    tx_mem[tx_wr]     = it.data;
                    tx_written[tx_wr] = 1'b1;
                    tx_wr             = next_idx(tx_wr, tx_len);
                    r.done_res        = 1'b1;
                end
            end
            OP_LINE_RX: begin
                err_bits = it.line_errors;
                if (next_idx(rx_wr, rx_len) == rx_rd) begin
                    ovf_flag = 1'b1;
                end else begin
                    rx_mem[rx_wr]     = it.data;
                    rx_written[rx_wr] = 1'b1;
                    rx_wr             = next_idx(rx_wr, rx_len);
                end
            end
            OP_TX_DONE: begin
                if (tx_active && tx_rd != tx_wr) begin
                    r.send_now  = 1'b1;
                    r.send_byte = tx_mem[tx_rd];
                    tx_rd       = next_idx(tx_rd, tx_len);
                end else begin
                    tx_active = 1'b0;
                end
            end
            OP_CLEAR_RX: rx_wr = rx_rd;
            OP_READ_OVF: ovf_flag = 1'b0;
            default: ;
        endcase
        r.overflow_seen    = (it.opcode == OP_READ_OVF) ? ovf_before : ovf_flag;
        r.last_line_errors = err_bits;
        return r;
    endfunction

    // Present one item, wait for it to be taken, then maybe idle a while
    task automatic send_op(logic [2:0] opc, logic [7:0] d, logic [2:0] errs);
        t_in_item it;
        int       gap;
        it     = '{opcode: opc, data: d, line_errors: errs};
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        uart_replies.push_back(uart_op_effect(it));
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_replies_done();
        if (start) start <= 1'b0;
        while (uart_replies.size() != 0) @(posedge i_clk);
    endtask

    // Write a ring length register. A ring still holding data is emptied first
    // when drain is set or not every entry of its store holds a known byte.
    task automatic set_ring_len(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val,
                                bit drain);
        if (idx == CFG_RX_SIZE) begin
            if (rx_rd != rx_wr && (drain || rx_written != '1)) begin
                if ($urandom_range(0, 1)) begin
                    send_op(OP_CLEAR_RX, 8'($urandom), 3'($urandom));
                end else begin
                    while (rx_rd != rx_wr) send_op(OP_HOST_READ, 8'($urandom), 3'($urandom));
                end
            end
        end else begin
            while (tx_rd != tx_wr && (drain || tx_written != '1))
                send_op(OP_TX_DONE, 8'($urandom), 3'($urandom));
        end
        wait_replies_done();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RX_SIZE) rx_len = ring_len(val);
        else tx_len = ring_len(val);
        @(posedge i_clk);
    endtask

    // Random items drawn from a mix that changes every few dozen items
    task automatic run_traffic(int n_items);
        int         mix;
        int         p;
        int         k;
        logic [2:0] opc;
        mix = MIX_EVEN;
        for (int i = 0; i < n_items; i++) begin
            if (i % 30 == 0) mix = $urandom_range(MIX_EVEN, MIX_DRAIN);
            // now and then hold off until the core has caught up
            if ($urandom_range(0, 99) == 0) wait_replies_done();
            p = $urandom_range(0, 99);
            k = 0;
            while (k < 6 && p >= MIX_CUT[mix][k]) k++;
            opc = (k < 6) ? OP_BY_SLOT[k] : ($urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7);
            send_op(opc, 8'($urandom), 3'($urandom));
        end
    endtask

    // Every opcode at the reset lengths, including the idle and empty cases
    task automatic test_basic_ops();
        idle_pct = 0;
        send_op(OP_HOST_READ, 8'h00, 3'd0);     // read of an empty ring
        send_op(OP_TX_DONE, 8'h00, 3'd0);       // tx done while idle
        send_op(OP_READ_OVF, 8'h00, 3'd0);
        send_op(OP_UNUSED_6, 8'hFF, 3'd7);
        send_op(OP_UNUSED_7, 8'h00, 3'd0);
        send_op(OP_LINE_RX, 8'h00, 3'd0);
        send_op(OP_LINE_RX, 8'hFF, 3'd7);
        send_op(OP_LINE_RX, 8'hA5, 3'd2);
        send_op(OP_HOST_WRITE, 8'hFF, 3'd0);    // sent directly
        send_op(OP_HOST_WRITE, 8'h00, 3'd7);    // queued
        send_op(OP_TX_DONE, 8'h00, 3'd0);       // pops the queued byte
        send_op(OP_TX_DONE, 8'h00, 3'd0);       // back to idle
        send_op(OP_HOST_READ, 8'h00, 3'd0);
        send_op(OP_CLEAR_RX, 8'h00, 3'd0);
        send_op(OP_HOST_READ, 8'h00, 3'd0);
    endtask

    // Shortest rings: overflow on receive, refused write on transmit
    task automatic test_full_rings();
        set_ring_len(CFG_RX_SIZE, 7'd0, 1'b1);
        set_ring_len(CFG_TX_SIZE, 7'd2, 1'b1);
        idle_pct = 49;
        send_op(OP_LINE_RX, 8'h11, 3'd4);
        send_op(OP_LINE_RX, 8'h22, 3'd1);       // ring full: dropped, overflow set
        send_op(OP_READ_OVF, 8'h00, 3'd0);
        send_op(OP_READ_OVF, 8'h00, 3'd0);
        send_op(OP_HOST_WRITE, 8'h5A, 3'd0);
        send_op(OP_HOST_WRITE, 8'hC3, 3'd0);
        send_op(OP_HOST_WRITE, 8'h3C, 3'd0);    // ring full while busy: refused
        send_op(OP_TX_DONE, 8'h00, 3'd0);
        send_op(OP_TX_DONE, 8'h00, 3'd0);
        send_op(OP_HOST_READ, 8'h00, 3'd0);
        send_op(OP_HOST_READ, 8'h00, 3'd0);
    endtask

    // Out-of-range and boundary length values, with traffic at each
    task automatic test_len_saturation();
        logic [CFG_DATA_W-1:0] lens [5] = '{7'd127, 7'd65, 7'd1, 7'd0, 7'd64};
        idle_pct = 13;
        foreach (lens[i]) begin
            set_ring_len(CFG_RX_SIZE, lens[i], 1'b1);
            set_ring_len(CFG_TX_SIZE, lens[i], 1'b1);
            run_traffic(30);
        end
    endtask

    // Write every entry of both stores at least once at full length
    task automatic test_store_fill();
        idle_pct = 0;
        set_ring_len(CFG_RX_SIZE, 7'd64, 1'b1);
        set_ring_len(CFG_TX_SIZE, 7'd64, 1'b1);
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_op(OP_LINE_RX, 8'($urandom), 3'($urandom));
            send_op(OP_HOST_READ, 8'($urandom), 3'($urandom));
        end
        send_op(OP_HOST_WRITE, 8'($urandom), 3'($urandom));
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_op(OP_HOST_WRITE, 8'($urandom), 3'($urandom));
            send_op(OP_TX_DONE, 8'($urandom), 3'($urandom));
        end
    endtask

    // Random traffic across lengths and idle rates; lengths may now change
    // while the rings hold data
    task automatic test_random_traffic();
        int idle_rates [3] = '{0, 49, 13};
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = idle_rates[ph % 3];
            if (ph == 2) begin
                set_ring_len(CFG_RX_SIZE, 7'($urandom), bit'($urandom));
                set_ring_len(CFG_TX_SIZE, 7'($urandom), bit'($urandom));
            end else if (ph == 4) begin
                set_ring_len(CFG_RX_SIZE, 7'd64, bit'($urandom));
                set_ring_len(CFG_TX_SIZE, 7'd64, bit'($urandom));
            end else begin
                set_ring_len(CFG_RX_SIZE, 7'($urandom_range(2, 8)), bit'($urandom));
                set_ring_len(CFG_TX_SIZE, 7'($urandom_range(2, 8)), bit'($urandom));
            end
            run_traffic(120);
        end
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Compare each strobed result with the oldest outstanding one
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (uart_replies.size() == 0) begin
                $error("result strobed with no item outstanding");
                mismatches++;
            end else begin
                want = uart_replies.pop_front();
                check_field("done_res", 8'(want.done_res), 8'(o_result.done_res));
                check_field("read_byte", want.read_byte, o_result.read_byte);
                check_field("send_now", 8'(want.send_now), 8'(o_result.send_now));
                check_field("send_byte", want.send_byte, o_result.send_byte);
                check_field("overflow_seen", 8'(want.overflow_seen),
                            8'(o_result.overflow_seen));
                check_field("last_line_errors", 8'(want.last_line_errors),
                            8'(o_result.last_line_errors));
            end
        end
    end

    // Watchdog: no item taken and no result for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        foreach (rx_mem[i]) rx_mem[i] = '0;
        foreach (tx_mem[i]) tx_mem[i] = '0;
        rx_written = '0;
        tx_written = '0;
        rx_rd      = 0;
        rx_wr      = 0;
        tx_rd      = 0;
        tx_wr      = 0;
        rx_len     = RING_DEPTH;
        tx_len     = RING_DEPTH;
        tx_active  = 1'b0;
        ovf_flag   = 1'b0;
        err_bits   = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_full_rings();
        test_len_saturation();
        test_store_fill();
        test_random_traffic();

        wait_replies_done();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
